[rtl/sngh_pkg.sv]
`timescale 1ns / 1ps
package sngh_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COEFF_BITS  = 24;
  localparam int LEVEL_BITS  = SAMPLE_BITS - 1;
  localparam int GAIN_FRAC   = 23;
  localparam int GAIN_BITS   = GAIN_FRAC + 1;
  localparam int HOLD_BITS   = 16;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = (COEFF_BITS > LEVEL_BITS) ? COEFF_BITS : LEVEL_BITS;

  // Shared multiplier: signed operands one bit wider than the widest unsigned value.
  localparam int MAX_SC   = (SAMPLE_BITS > COEFF_BITS) ? SAMPLE_BITS : COEFF_BITS;
  localparam int OP_BITS  = ((MAX_SC > GAIN_BITS) ? MAX_SC : GAIN_BITS) + 1;
  localparam int PROD_BITS = 2 * OP_BITS;
  localparam int FRESH_BITS = (LEVEL_BITS > GAIN_BITS) ? LEVEL_BITS : GAIN_BITS;
  localparam int WIDE_BITS  = PROD_BITS - COEFF_BITS;

  localparam logic [LEVEL_BITS-1:0] MAG_MAX    = '1;
  localparam logic [GAIN_BITS-1:0]  GAIN_UNITY = GAIN_BITS'(1) << GAIN_FRAC;
  localparam logic [GAIN_BITS-1:0]  GAIN_FLOOR = GAIN_BITS'(265);

  localparam logic                  RST_GATE_ENABLE = 1'b1;
  localparam logic [COEFF_BITS-1:0] RST_DET_ATTACK  = COEFF_BITS'(9965000);
  localparam logic [COEFF_BITS-1:0] RST_DET_RELEASE = COEFF_BITS'(16733600);
  localparam logic [COEFF_BITS-1:0] RST_OPEN_GLIDE  = COEFF_BITS'(12930000);
  localparam logic [COEFF_BITS-1:0] RST_CLOSE_GLIDE = COEFF_BITS'(16757800);
  localparam logic [LEVEL_BITS-1:0] RST_OPEN_LEVEL  = LEVEL_BITS'(1400);
  localparam logic [LEVEL_BITS-1:0] RST_CLOSE_LEVEL = LEVEL_BITS'(700);
  localparam logic [HOLD_BITS-1:0]  RST_HOLD_LENGTH = HOLD_BITS'(288);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_GATE_ENABLE  = 3'd0,
    CFG_DET_ATTACK   = 3'd1,
    CFG_DET_RELEASE  = 3'd2,
    CFG_OPEN_GLIDE   = 3'd3,
    CFG_CLOSE_GLIDE  = 3'd4,
    CFG_OPEN_LEVEL   = 3'd5,
    CFG_CLOSE_LEVEL  = 3'd6,
    CFG_HOLD_LENGTH  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic load_in;
    logic env_mul;
    logic env_upd;
    logic gate_upd;
    logic gain_mul;
    logic gain_upd;
    logic left_mul;
    logic right_mul;
    logic out_load;
  } sngh_cmd_t;

  typedef struct packed {
    logic out_free;
  } sngh_sts_t;

endpackage

[rtl/sngh_if.sv]
`timescale 1ns / 1ps
interface sngh_in_if import sngh_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;
  logic                          block_end;

  modport source (output valid, left_sample, right_sample, block_end, input ready);
  modport sink   (input valid, left_sample, right_sample, block_end, output ready);
endinterface

interface sngh_out_if import sngh_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_gated;
  logic signed [SAMPLE_BITS-1:0] right_gated;
  logic                          gate_closed;
  logic                          block_end_out;

  modport source (output valid, left_gated, right_gated, gate_closed, block_end_out,
                  input ready);
  modport sink   (input valid, left_gated, right_gated, gate_closed, block_end_out,
                  output ready);
endinterface

[rtl/sngh_ctrl.sv]
`timescale 1ns / 1ps
module sngh_ctrl import sngh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  sngh_sts_t sts,
  output sngh_cmd_t cmd
);

  typedef enum logic [8:0] {
    ST_IDLE      = 9'b000000001,
    ST_ENV_MUL   = 9'b000000010,
    ST_ENV_UPD   = 9'b000000100,
    ST_GATE_UPD  = 9'b000001000,
    ST_GAIN_MUL  = 9'b000010000,
    ST_GAIN_UPD  = 9'b000100000,
    ST_LEFT_MUL  = 9'b001000000,
    ST_RIGHT_MUL = 9'b010000000,
    ST_DONE      = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.load_in = in_valid;
        if (in_valid) state_next = ST_ENV_MUL;
      end
      ST_ENV_MUL: begin
        cmd.env_mul = 1'b1;
        state_next  = ST_ENV_UPD;
      end
      ST_ENV_UPD: begin
        cmd.env_upd = 1'b1;
        state_next  = ST_GATE_UPD;
      end
      ST_GATE_UPD: begin
        cmd.gate_upd = 1'b1;
        state_next   = ST_GAIN_MUL;
      end
      ST_GAIN_MUL: begin
        cmd.gain_mul = 1'b1;
        state_next   = ST_GAIN_UPD;
      end
      ST_GAIN_UPD: begin
        cmd.gain_upd = 1'b1;
        state_next   = ST_LEFT_MUL;
      end
      ST_LEFT_MUL: begin
        cmd.left_mul = 1'b1;
        state_next   = ST_RIGHT_MUL;
      end
      ST_RIGHT_MUL: begin
        cmd.right_mul = 1'b1;
        state_next    = ST_DONE;
      end
      ST_DONE: begin
        // The finished item waits here until the output register has room.
        cmd.out_load = sts.out_free;
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/sngh_datapath.sv]
`timescale 1ns / 1ps
module sngh_datapath import sngh_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  sngh_cmd_t                     cmd,
  output sngh_sts_t                     sts,
  input  logic                          cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  input  logic                          block_end,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] left_gated,
  output logic signed [SAMPLE_BITS-1:0] right_gated,
  output logic                          gate_closed,
  output logic                          block_end_out
);

  localparam logic signed [PROD_BITS-1:0] HALF_COEFF = PROD_BITS'(1) << (COEFF_BITS - 1);
  localparam logic signed [PROD_BITS-1:0] HALF_GAIN  = PROD_BITS'(1) << (GAIN_FRAC - 1);
  localparam logic signed [PROD_BITS-1:0] SAT_HI     = PROD_BITS'(MAG_MAX);
  localparam logic signed [PROD_BITS-1:0] SAT_LO     = -SAT_HI - PROD_BITS'(1);

  // Configuration registers.
  logic                  gate_enable;
  logic [COEFF_BITS-1:0] det_attack_coeff;
  logic [COEFF_BITS-1:0] det_release_coeff;
  logic [COEFF_BITS-1:0] open_glide_coeff;
  logic [COEFF_BITS-1:0] close_glide_coeff;
  logic [LEVEL_BITS-1:0] open_level;
  logic [LEVEL_BITS-1:0] close_level;
  logic [HOLD_BITS-1:0]  hold_length;

  // Gate state.
  logic [LEVEL_BITS-1:0] envelope;
  logic [GAIN_BITS-1:0]  gain;
  logic [HOLD_BITS-1:0]  hold_left;
  logic                  is_open;

  // Per-item working registers.
  logic signed [SAMPLE_BITS-1:0] left_s;
  logic signed [SAMPLE_BITS-1:0] right_s;
  logic                          block_end_s;
  logic [LEVEL_BITS-1:0]         peak;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [SAMPLE_BITS-1:0] left_res;

  logic [LEVEL_BITS-1:0]       mag_l, mag_r;
  logic [COEFF_BITS-1:0]       env_coeff, glide_coeff;
  logic [GAIN_BITS-1:0]        target;
  logic signed [OP_BITS-1:0]   a_op, b_op;
  logic [FRESH_BITS-1:0]       fresh;
  logic signed [PROD_BITS-1:0] acc;
  logic [WIDE_BITS-1:0]        acc_hi;
  logic [LEVEL_BITS-1:0]       env_next;
  logic [GAIN_BITS-1:0]        gain_next;
  logic                        out_free;

  // Magnitude of a sample; full-scale negative saturates to the largest positive value.
  function automatic logic [LEVEL_BITS-1:0] mag(input logic signed [SAMPLE_BITS-1:0] s);
    logic [SAMPLE_BITS-1:0] a;
    a = s[SAMPLE_BITS-1] ? (~s + 1'b1) : s;
    return a[SAMPLE_BITS-1] ? MAG_MAX : a[LEVEL_BITS-1:0];
  endfunction

  // Sample times gain, rounded half up with floor division, then saturated.
  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
    input logic signed [PROD_BITS-1:0] pr
  );
    logic signed [PROD_BITS-1:0] q;
    q = (pr + HALF_GAIN) >>> GAIN_FRAC;
    if (q > SAT_HI) q = SAT_HI;
    if (q < SAT_LO) q = SAT_LO;
    return q[SAMPLE_BITS-1:0];
  endfunction

  assign mag_l       = mag(left_sample);
  assign mag_r       = mag(right_sample);
  assign env_coeff   = (peak > envelope) ? det_attack_coeff : det_release_coeff;
  assign target      = is_open ? GAIN_UNITY : GAIN_FLOOR;
  assign glide_coeff = (target > gain) ? open_glide_coeff : close_glide_coeff;

  // The filter update is written as fresh + c * (old - fresh), so one multiply serves it.
  always_comb begin
    a_op = '0;
    b_op = '0;
    if (cmd.env_mul) begin
      a_op = $signed(OP_BITS'(env_coeff));
      b_op = $signed(OP_BITS'(envelope)) - $signed(OP_BITS'(peak));
    end else if (cmd.gain_mul) begin
      a_op = $signed(OP_BITS'(glide_coeff));
      b_op = $signed(OP_BITS'(gain)) - $signed(OP_BITS'(target));
    end else if (cmd.left_mul) begin
      a_op = OP_BITS'(left_s);
      b_op = $signed(OP_BITS'(gain));
    end else if (cmd.right_mul) begin
      a_op = OP_BITS'(right_s);
      b_op = $signed(OP_BITS'(gain));
    end
  end

  assign fresh  = cmd.env_upd ? FRESH_BITS'(peak) : FRESH_BITS'(target);
  assign acc    = (PROD_BITS'(fresh) << COEFF_BITS) + prod + HALF_COEFF;
  assign acc_hi = acc[PROD_BITS-1:COEFF_BITS];

  assign env_next  = (acc_hi > WIDE_BITS'(MAG_MAX)) ? MAG_MAX : acc_hi[LEVEL_BITS-1:0];
  assign gain_next = (acc_hi > WIDE_BITS'(GAIN_UNITY)) ? GAIN_UNITY : acc_hi[GAIN_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_enable       <= RST_GATE_ENABLE;
      det_attack_coeff  <= RST_DET_ATTACK;
      det_release_coeff <= RST_DET_RELEASE;
      open_glide_coeff  <= RST_OPEN_GLIDE;
      close_glide_coeff <= RST_CLOSE_GLIDE;
      open_level        <= RST_OPEN_LEVEL;
      close_level       <= RST_CLOSE_LEVEL;
      hold_length       <= RST_HOLD_LENGTH;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_GATE_ENABLE: gate_enable       <= cfg_data[0];
        CFG_DET_ATTACK:  det_attack_coeff  <= cfg_data[COEFF_BITS-1:0];
        CFG_DET_RELEASE: det_release_coeff <= cfg_data[COEFF_BITS-1:0];
        CFG_OPEN_GLIDE:  open_glide_coeff  <= cfg_data[COEFF_BITS-1:0];
        CFG_CLOSE_GLIDE: close_glide_coeff <= cfg_data[COEFF_BITS-1:0];
        CFG_OPEN_LEVEL:  open_level        <= cfg_data[LEVEL_BITS-1:0];
        CFG_CLOSE_LEVEL: close_level       <= cfg_data[LEVEL_BITS-1:0];
        CFG_HOLD_LENGTH: hold_length       <= cfg_data[HOLD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      envelope  <= '0;
      gain      <= GAIN_UNITY;
      hold_left <= '0;
      is_open   <= 1'b1;
    end else begin
      if (cmd.env_upd) envelope <= env_next;
      if (cmd.gain_upd) gain <= gain_next;
      if (cmd.gate_upd) begin
        if (!gate_enable || envelope >= open_level) begin
          is_open   <= 1'b1;
          hold_left <= hold_length;
        end else if (is_open) begin
          if (envelope >= close_level) begin
            hold_left <= hold_length;
          end else if (hold_left != '0) begin
            hold_left <= hold_left - 1'b1;
          end else begin
            is_open <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      left_s      <= left_sample;
      right_s     <= right_sample;
      block_end_s <= block_end;
      peak        <= (mag_r > mag_l) ? mag_r : mag_l;
    end
    if (cmd.env_mul || cmd.gain_mul || cmd.left_mul || cmd.right_mul) begin
      prod <= a_op * b_op;
    end
    if (cmd.right_mul) begin
      left_res <= round_sat(prod);
    end
  end

  assign out_free     = !out_valid || out_ready;
  assign sts.out_free = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      left_gated    <= left_res;
      right_gated   <= round_sat(prod);
      gate_closed   <= gate_enable && !is_open;
      block_end_out <= block_end_s;
    end
  end

endmodule

[rtl/stereo_noise_gate_with_hold.sv]
`timescale 1ns / 1ps
// Channel   Interface    Dir  Contents
// din       sngh_in_if   in   left_sample, right_sample, block_end
// dout      sngh_out_if  out  left_gated, right_gated, gate_closed, block_end_out
// cfg       write port   in   cfg_wr_en, cfg_index, cfg_data
//
// Each item is sequenced from acceptance to its result in the output register: one
// shared signed multiplier is used in turn for the envelope, the gain and the two channels.
// The input is ready only while the sequencer is idle: no item is taken until the last
// one is loaded. Reset is synchronous and restores the registers and the gate state.
// A result held in the output register stalls the sequencer in its last step.
module stereo_noise_gate_with_hold import sngh_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  sngh_in_if.sink                   din,
  sngh_out_if.source                dout,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  sngh_cmd_t cmd;
  sngh_sts_t sts;
  logic      in_ready;

  assign din.ready = in_ready;

  sngh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sngh_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .left_sample   (din.left_sample),
    .right_sample  (din.right_sample),
    .block_end     (din.block_end),
    .out_ready     (dout.ready),
    .out_valid     (dout.valid),
    .left_gated    (dout.left_gated),
    .right_gated   (dout.right_gated),
    .gate_closed   (dout.gate_closed),
    .block_end_out (dout.block_end_out)
  );

endmodule

[rtl/sngh_checker.sv]
`timescale 1ns / 1ps
module sngh_checker import sngh_pkg::*; (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] left_gated,
  input logic signed [SAMPLE_BITS-1:0] right_gated,
  input logic                          gate_closed,
  input logic                          block_end_out
);

  // A stalled result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_gated) && $stable(right_gated)
      && $stable(gate_closed) && $stable(block_end_out))
    else $error("result changed while stalled");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready straight after an accepted item");

  // A new result appears in the same cycle as the sequencer returns to idle.
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result appeared while an item was still in work");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind stereo_noise_gate_with_hold sngh_checker u_sngh_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (din.valid),
  .in_ready      (din.ready),
  .out_valid     (dout.valid),
  .out_ready     (dout.ready),
  .left_gated    (dout.left_gated),
  .right_gated   (dout.right_gated),
  .gate_closed   (dout.gate_closed),
  .block_end_out (dout.block_end_out)
);
